// ----- src/cmte_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the CAN message table with emergency stop.
// No dependencies; cmte_if, cmte_update and the top level use this package.
package cmte_pkg;

  localparam int unsigned IdW          = 11;
  localparam int unsigned OpW          = 2;
  localparam int unsigned ByteW        = 8;
  localparam int unsigned PayloadBytes = 8;
  localparam int unsigned PayloadW     = ByteW * PayloadBytes;
  localparam int unsigned IdCountDef   = 2048;

  // Item opcodes; code 3 carries no operation
  typedef enum logic [OpW-1:0] {
    OP_RECV  = 2'd0,
    OP_WRITE = 2'd1,
    OP_QUERY = 2'd2
  } op_e;

  // Input item
  typedef struct packed {
    logic [OpW-1:0]   opcode;
    logic [IdW-1:0]   msg_id;
    logic [ByteW-1:0] data_byte_0;
    logic [ByteW-1:0] data_byte_1;
    logic [ByteW-1:0] data_byte_2;
    logic [ByteW-1:0] data_byte_3;
    logic [ByteW-1:0] data_byte_4;
    logic [ByteW-1:0] data_byte_5;
    logic [ByteW-1:0] data_byte_6;
    logic [ByteW-1:0] data_byte_7;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [ByteW-1:0] read_byte_0;
    logic [ByteW-1:0] read_byte_1;
    logic [ByteW-1:0] read_byte_2;
    logic [ByteW-1:0] read_byte_3;
    logic [ByteW-1:0] read_byte_4;
    logic [ByteW-1:0] read_byte_5;
    logic [ByteW-1:0] read_byte_6;
    logic [ByteW-1:0] read_byte_7;
    logic             entry_known;
    logic             entry_changed;
    logic             frame_dropped;
    logic             stop_active;
  } out_item_t;

  // One table entry as stored in the RAM
  typedef struct packed {
    logic                valid;
    logic                flag;
    logic [PayloadW-1:0] payload;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  // Decision of the update logic for one item
  typedef struct packed {
    logic      wr_en;
    entry_t    wr_word;
    logic      engage;
    logic      estop_next;
    out_item_t res;
  } upd_t;

endpackage

// ----- src/cmte_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channels of the message table: input items and result items.
// Depends on cmte_pkg for the payload types.
interface cmte_in_if;
  logic                 valid;
  logic                 ready;
  cmte_pkg::in_item_t   item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface cmte_out_if;
  logic                 valid;
  logic                 ready;
  cmte_pkg::out_item_t  item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

// ----- src/cmte_ram.sv -----
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module cmte_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // read port, data held while not enabled
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

// ----- src/cmte_update.sv -----
`timescale 1ns / 1ps
// Per-item update logic: decides the entry write, the stop bit and the result.
// Depends on cmte_pkg.
module cmte_update #(
  parameter int unsigned ID_COUNT = cmte_pkg::IdCountDef
) (
  input  cmte_pkg::in_item_t         item_i,
  input  cmte_pkg::entry_t           entry_i,
  input  logic [cmte_pkg::IdW-1:0]   stop_id_i,
  input  logic                       estop_i,
  output cmte_pkg::upd_t             upd_o
);
  import cmte_pkg::*;

  localparam logic [IdW:0] IdLimit = (IdW+1)'(ID_COUNT);

  logic                in_range;
  logic                is_stop;
  logic                known;
  logic                store;
  logic                flag_new;
  logic [PayloadW-1:0] payload;
  logic [PayloadW-1:0] rdback;

  assign payload = {item_i.data_byte_7, item_i.data_byte_6, item_i.data_byte_5,
                    item_i.data_byte_4, item_i.data_byte_3, item_i.data_byte_2,
                    item_i.data_byte_1, item_i.data_byte_0};

  always_comb begin
    in_range = ({1'b0, item_i.msg_id} < IdLimit);
    is_stop  = (item_i.msg_id == stop_id_i);
    // the stop entry counts as known whenever its ID is in range
    known    = in_range && (entry_i.valid || is_stop);
    store    = 1'b0;
    flag_new = !known || (entry_i.payload != payload);
    rdback   = '0;

    upd_o                   = '0;
    upd_o.estop_next        = estop_i;
    upd_o.res.entry_known   = known;
    upd_o.res.entry_changed = known && entry_i.flag;

    unique case (item_i.opcode)
      OP_RECV: begin
        // stop filter
        if (!estop_i) begin
          if (is_stop && (item_i.data_byte_0 == ByteW'(1))) begin
            upd_o.engage     = 1'b1;
            upd_o.estop_next = 1'b1;
          end else begin
            store = 1'b1;
          end
        end else if (is_stop && (item_i.data_byte_0 == '0)) begin
          upd_o.estop_next = 1'b0;
          store            = 1'b1;
        end
        if (store && in_range) begin
          upd_o.wr_en             = 1'b1;
          upd_o.wr_word.valid     = 1'b1;
          upd_o.wr_word.flag      = flag_new;
          upd_o.wr_word.payload   = payload;
          upd_o.res.entry_known   = 1'b1;
          upd_o.res.entry_changed = flag_new;
        end else begin
          upd_o.res.frame_dropped = 1'b1;
        end
      end
      OP_WRITE: begin
        // store without touching the flag
        if (in_range) begin
          upd_o.wr_en           = 1'b1;
          upd_o.wr_word.valid   = 1'b1;
          upd_o.wr_word.flag    = entry_i.flag;
          upd_o.wr_word.payload = payload;
          upd_o.res.entry_known = 1'b1;
        end
      end
      OP_QUERY: begin
        if (known) begin
          rdback = entry_i.payload;
        end
      end
      default: begin
        upd_o.res.entry_known   = 1'b0;
        upd_o.res.entry_changed = 1'b0;
      end
    endcase

    upd_o.res.read_byte_0 = rdback[0*ByteW +: ByteW];
    upd_o.res.read_byte_1 = rdback[1*ByteW +: ByteW];
    upd_o.res.read_byte_2 = rdback[2*ByteW +: ByteW];
    upd_o.res.read_byte_3 = rdback[3*ByteW +: ByteW];
    upd_o.res.read_byte_4 = rdback[4*ByteW +: ByteW];
    upd_o.res.read_byte_5 = rdback[5*ByteW +: ByteW];
    upd_o.res.read_byte_6 = rdback[6*ByteW +: ByteW];
    upd_o.res.read_byte_7 = rdback[7*ByteW +: ByteW];
    upd_o.res.stop_active = upd_o.estop_next;
  end

endmodule

// ----- src/can_message_table_with_estop_core.sv -----
`timescale 1ns / 1ps
// CAN message table with emergency stop: top level, sequencer and table RAM.
// Depends on cmte_pkg, cmte_if, cmte_ram and cmte_update.
//
// Usage:
//   in_i carries items (opcode, msg_id, eight payload bytes); out_o returns
//   exactly one result item per input item, in order. Both are valid/ready.
//   cfg_we_i/cfg_wdata_i write the stop message ID; the user must do so only
//   while the block is idle, as the block itself does not enforce it.
// Sequence:
//   An item first reads its entry from the table RAM, then updates the entry
//   and loads the output register; the next item is accepted back in idle.
// Stop engage:
//   A stop frame that sets the stop bit starts a walk over all ID_COUNT
//   entries, one per cycle, that zeroes and flags every valid entry but the
//   stop entry; input is held off until the walk ends.
// Reset:
//   After reset the block clears the table, one entry per cycle, before the
//   first item is accepted.
// Stalls:
//   The output register holds a result until taken; one further item may be
//   accepted meanwhile and waits in the update step until the register frees.
module can_message_table_with_estop_core #(
  parameter int unsigned ID_COUNT = cmte_pkg::IdCountDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [cmte_pkg::IdW-1:0] cfg_wdata_i,
  cmte_in_if.sink                  in_i,
  cmte_out_if.source               out_o
);
  import cmte_pkg::*;

  localparam int unsigned AddrW = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1;
  localparam logic [AddrW-1:0] LastAddr = AddrW'(ID_COUNT - 1);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_EXEC  = 4'b0100,
    ST_WALK  = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  logic [IdW-1:0]   stop_id_q;
  logic             estop_q, estop_d;
  logic [AddrW-1:0] cnt_q, cnt_d;
  logic             issue_q, issue_d;
  logic             wb_valid_q, wb_valid_d;
  logic [AddrW-1:0] wb_addr_q, wb_addr_d;
  in_item_t         item_q;
  out_item_t        out_q;
  logic             out_valid_q, out_valid_d;

  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  entry_t           ram_wdata;
  logic             ram_re;
  logic [AddrW-1:0] ram_raddr;
  entry_t           ram_rdata;
  upd_t             upd;
  logic             accept;
  logic             fire;

  // table RAM
  cmte_ram #(
    .Width (EntryW),
    .Depth (ID_COUNT)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (ram_waddr),
    .wr_data_i (ram_wdata),
    .rd_en_i   (ram_re),
    .rd_addr_i (ram_raddr),
    .rd_data_o (ram_rdata)
  );

  // entry update
  cmte_update #(
    .ID_COUNT (ID_COUNT)
  ) u_update (
    .item_i    (item_q),
    .entry_i   (ram_rdata),
    .stop_id_i (stop_id_q),
    .estop_i   (estop_q),
    .upd_o     (upd)
  );

  assign in_i.ready  = (state_q == ST_IDLE);
  assign accept      = in_i.valid && in_i.ready;
  assign fire        = (state_q == ST_EXEC) && (!out_valid_q || out_o.ready);
  assign out_o.valid = out_valid_q;
  assign out_o.item  = out_q;

  // sequencer and RAM port muxing
  always_comb begin
    state_d     = state_q;
    estop_d     = estop_q;
    cnt_d       = cnt_q;
    issue_d     = issue_q;
    wb_valid_d  = 1'b0;
    wb_addr_d   = cnt_q;
    out_valid_d = out_valid_q && !out_o.ready;
    ram_we      = 1'b0;
    ram_waddr   = cnt_q;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = in_i.item.msg_id[AddrW-1:0];

    unique case (state_q)
      ST_CLEAR: begin
        ram_we = 1'b1;
        if (cnt_q == LastAddr) begin
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_IDLE: begin
        ram_re = accept;
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        ram_waddr = item_q.msg_id[AddrW-1:0];
        ram_wdata = upd.wr_word;
        if (fire) begin
          ram_we      = upd.wr_en;
          estop_d     = upd.estop_next;
          out_valid_d = 1'b1;
          if (upd.engage) begin
            state_d = ST_WALK;
            cnt_d   = '0;
            issue_d = 1'b1;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_WALK: begin
        // read entry cnt_q, write back the entry read in the previous cycle
        ram_re          = issue_q;
        ram_raddr       = cnt_q;
        ram_waddr       = wb_addr_q;
        ram_wdata.valid = 1'b1;
        ram_wdata.flag  = 1'b1;
        ram_we          = wb_valid_q && ram_rdata.valid
                          && (IdW'(wb_addr_q) != stop_id_q);
        wb_valid_d      = issue_q;
        if (issue_q) begin
          if (cnt_q == LastAddr) begin
            issue_d = 1'b0;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      estop_q     <= 1'b0;
      cnt_q       <= '0;
      issue_q     <= 1'b0;
      wb_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      stop_id_q   <= '0;
    end else begin
      state_q     <= state_d;
      estop_q     <= estop_d;
      cnt_q       <= cnt_d;
      issue_q     <= issue_d;
      wb_valid_q  <= wb_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        stop_id_q <= cfg_wdata_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    wb_addr_q <= wb_addr_d;
    if (accept) begin
      item_q <= in_i.item;
    end
    if (fire) begin
      out_q <= upd.res;
    end
  end

endmodule
